// File: rtl/sed_pkg.sv
// Shared types and constants for the signed Euclidean divider.
package sed_pkg;

    localparam int SED_DATA_WIDTH = 32;

    // Per-item side information carried down the pipeline.
    typedef struct packed {
        logic a_neg;          // dividend negative
        logic d_neg;          // divisor negative
        logic zero_dividend;  // dividend is zero
        logic zero_divisor;   // divisor is zero, dividend nonzero
    } sed_flags_t;

endpackage

// File: rtl/sed_split.sv
// Input stage: sign/magnitude split of dividend and divisor.
module sed_split
    import sed_pkg::*;
#(
    parameter int DATA_WIDTH = SED_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_dividend,
    input  logic [DATA_WIDTH-1:0] in_divisor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_ua,
    output logic [DATA_WIDTH-1:0] out_ud,
    output sed_flags_t            out_flags
);

    localparam int DW = DATA_WIDTH;

    logic            valid_reg;
    logic [DW-1:0]   ua_reg;
    logic [DW-1:0]   ud_reg;
    sed_flags_t      flags_reg;

    logic [DW-1:0]   ua_next;
    logic [DW-1:0]   ud_next;
    sed_flags_t      flags_next;
    logic            load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        ua_next                  = in_dividend[DW-1] ? (~in_dividend + 1'b1) : in_dividend;
        ud_next                  = in_divisor[DW-1] ? (~in_divisor + 1'b1) : in_divisor;
        flags_next.a_neg         = in_dividend[DW-1];
        flags_next.d_neg         = in_divisor[DW-1];
        flags_next.zero_dividend = (in_dividend == '0);
        flags_next.zero_divisor  = (in_dividend != '0) && (in_divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ua_reg    <= ua_next;
            ud_reg    <= ud_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ua    = ua_reg;
    assign out_ud    = ud_reg;
    assign out_flags = flags_reg;

endmodule

// File: rtl/sed_step.sv
// One restoring-division stage: resolves one quotient bit per item.
module sed_step
    import sed_pkg::*;
#(
    parameter int DATA_WIDTH = SED_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_quo,
    input  logic [DATA_WIDTH-1:0] in_div,
    input  sed_flags_t            in_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic [DATA_WIDTH-1:0] out_quo,
    output logic [DATA_WIDTH-1:0] out_div,
    output sed_flags_t            out_flags
);

    localparam int DW = DATA_WIDTH;

    logic            valid_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   quo_reg;
    logic [DW-1:0]   div_reg;
    sed_flags_t      flags_reg;

    logic [DW-1:0]   shifted;
    logic [DW:0]     diff;
    logic [DW-1:0]   rem_next;
    logic [DW-1:0]   quo_next;
    logic            load;

    // quo holds the not-yet-used dividend bits on top, quotient bits below
    assign shifted  = {in_rem[DW-2:0], in_quo[DW-1]};
    assign diff     = {1'b0, shifted} - {1'b0, in_div};
    assign rem_next = diff[DW] ? shifted : diff[DW-1:0];
    assign quo_next = {in_quo[DW-2:0], ~diff[DW]};

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            div_reg   <= in_div;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;
    assign out_flags = flags_reg;

`ifndef SYNTHESIS
    // partial remainder always stays below a nonzero divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (div_reg != '0)) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

// File: rtl/sed_fix.sv
// Sign fixup stage: Euclidean correction of quotient magnitude and remainder.
module sed_fix
    import sed_pkg::*;
#(
    parameter int DATA_WIDTH = SED_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_quo,
    input  logic [DATA_WIDTH-1:0] in_div,
    input  sed_flags_t            in_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_qmag,
    output logic [DATA_WIDTH-2:0] out_rem,
    output logic                  out_qneg,
    output logic                  out_zero_divisor
);

    localparam int DW = DATA_WIDTH;

    logic            valid_reg;
    logic [DW-1:0]   qmag_reg;
    logic [DW-2:0]   rem_reg;
    logic            qneg_reg;
    logic            zdiv_reg;

    logic [DW-1:0]   qmag_next;
    logic [DW-1:0]   rem_next;
    logic            qneg_next;
    logic            load;

    always_comb
    begin
        qmag_next = in_quo;
        rem_next  = in_rem;
        qneg_next = in_flags.d_neg;
        if (in_flags.zero_dividend || in_flags.zero_divisor)
        begin
            qmag_next = '0;
            rem_next  = '0;
            qneg_next = 1'b0;
        end
        else if (in_flags.a_neg)
        begin
            qneg_next = !in_flags.d_neg;
            if (in_rem != '0)
            begin
                qmag_next = in_quo + 1'b1;
                rem_next  = in_div - in_rem;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            qmag_reg <= qmag_next;
            rem_reg  <= rem_next[DW-2:0];
            qneg_reg <= qneg_next;
            zdiv_reg <= in_flags.zero_divisor;
        end
    end

    assign out_valid        = valid_reg;
    assign out_qmag         = qmag_reg;
    assign out_rem          = rem_reg;
    assign out_qneg         = qneg_reg;
    assign out_zero_divisor = zdiv_reg;

`ifndef SYNTHESIS
    a_zdiv_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && zdiv_reg) |-> ((qmag_reg == '0) && (rem_reg == '0) && !qneg_reg))
        else $error("zero divisor item with nonzero result");
`endif

endmodule

// File: rtl/signed_euclidean_divider_top.sv
// Top level of the pipelined signed Euclidean divider.
//
//  channel   | dir | signals                    | contents
//  ----------+-----+----------------------------+----------------------------------
//  s_axis    | in  | s_tvalid s_tready s_tdata  | dividend, divisor
//  m_axis    | out | m_tvalid m_tready m_tdata  | quotient, remainder
//            |     | m_tuser                    | zero_divisor flag
//
// An accepted item passes these registers in order: the split register, which loads at
// the accepting edge, then one restoring-division stage per quotient bit, the sign
// fixup stage and the output register that applies the quotient sign; m_tvalid rises
// when the output register loads. One item can enter every cycle while m_tready holds no stall.
// A stalled m_tready fills bubbles first, then backs up to s_tready; nothing
// is dropped or repeated. rst_n clears only the valid bits.
module signed_euclidean_divider_top
    import sed_pkg::*;
#(
    parameter int DATA_WIDTH = SED_DATA_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // dividend [DATA_WIDTH-1:0], divisor [2*DATA_WIDTH-1:DATA_WIDTH], zero pad
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // quotient [DATA_WIDTH:0], remainder [2*DATA_WIDTH-1:DATA_WIDTH+1], zero pad
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
    // zero_divisor [0]
    output logic                                m_tuser
);

    localparam int DW      = DATA_WIDTH;
    localparam int TDATA_W = ((2*DW+7)/8)*8;

    // split stage outputs
    logic            sp_valid;
    logic            sp_ready;
    logic [DW-1:0]   sp_ua;
    logic [DW-1:0]   sp_ud;
    sed_flags_t      sp_flags;

    // division chain: index k feeds step k, index DW feeds the fixup
    logic            st_valid [0:DW];
    logic            st_ready [0:DW];
    logic [DW-1:0]   st_rem   [0:DW];
    logic [DW-1:0]   st_quo   [0:DW];
    logic [DW-1:0]   st_div   [0:DW];
    sed_flags_t      st_flags [0:DW];

    // fixup stage outputs
    logic            fx_valid;
    logic            fx_ready;
    logic [DW-1:0]   fx_qmag;
    logic [DW-2:0]   fx_rem;
    logic            fx_qneg;
    logic            fx_zdiv;

    // output register
    logic            out_valid_reg;
    logic [DW:0]     quo_reg;
    logic [DW-2:0]   rem_reg;
    logic            zdiv_reg;
    logic [DW:0]     quo_next;
    logic            out_load;

    sed_split #(
        .DATA_WIDTH (DW)
    ) u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_dividend (s_tdata[DW-1:0]),
        .in_divisor  (s_tdata[2*DW-1:DW]),
        .out_valid   (sp_valid),
        .out_ready   (sp_ready),
        .out_ua      (sp_ua),
        .out_ud      (sp_ud),
        .out_flags   (sp_flags)
    );

    // first step starts from a zero partial remainder
    assign st_valid[0] = sp_valid;
    assign sp_ready    = st_ready[0];
    assign st_rem[0]   = '0;
    assign st_quo[0]   = sp_ua;
    assign st_div[0]   = sp_ud;
    assign st_flags[0] = sp_flags;

    for (genvar k = 0; k < DW; k++)
    begin : g_step
        sed_step #(
            .DATA_WIDTH (DW)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_rem    (st_rem[k]),
            .in_quo    (st_quo[k]),
            .in_div    (st_div[k]),
            .in_flags  (st_flags[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_rem   (st_rem[k+1]),
            .out_quo   (st_quo[k+1]),
            .out_div   (st_div[k+1]),
            .out_flags (st_flags[k+1])
        );
    end

    sed_fix #(
        .DATA_WIDTH (DW)
    ) u_fix (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (st_valid[DW]),
        .in_ready         (st_ready[DW]),
        .in_rem           (st_rem[DW]),
        .in_quo           (st_quo[DW]),
        .in_div           (st_div[DW]),
        .in_flags         (st_flags[DW]),
        .out_valid        (fx_valid),
        .out_ready        (fx_ready),
        .out_qmag         (fx_qmag),
        .out_rem          (fx_rem),
        .out_qneg         (fx_qneg),
        .out_zero_divisor (fx_zdiv)
    );

    // output stage: apply quotient sign in DW+1 bits
    assign quo_next = fx_qneg ? (~{1'b0, fx_qmag} + 1'b1) : {1'b0, fx_qmag};
    assign fx_ready = !out_valid_reg || m_tready;
    assign out_load = fx_valid && fx_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fx_ready)
        begin
            out_valid_reg <= fx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= fx_rem;
            zdiv_reg <= fx_zdiv;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({rem_reg, quo_reg});
    assign m_tuser  = zdiv_reg;

`ifndef SYNTHESIS
    // zero-divisor results carry a zero quotient and remainder
    a_zdiv_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zdiv_reg) |-> ((quo_reg == '0) && (rem_reg == '0)))
        else $error("zero divisor result not cleared");
`endif
`ifndef SYNTHESIS
    // input only backs up once the whole pipe is full, so a result must wait
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled with output not blocked");
`endif

endmodule
